// ===== rtl/core/ule_pkg.sv =====
// ============================================================================
// ule_pkg: shared types and constants for the uuencode line encoder
// Command format between front and back, back sequencer states, character map.
// ============================================================================
`default_nettype none

package ule_pkg;

    // Default line length in bytes
    localparam int unsigned LINE_BYTES_DEF = 45;

    // Width of the fill count and the line length field
    localparam int unsigned LEN_W = 6;

    localparam logic [6:0] CHAR_NEWLINE  = 7'h0A;
    localparam logic [6:0] CHAR_BACKTICK = 7'h60;
    localparam logic [6:0] CHAR_BASE     = 7'h20;

    // One command per input item that produces text
    typedef struct packed {
        logic             has_line;
        logic [LEN_W-1:0] len;
        logic             bank;
        logic             has_term;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_FETCH,
        S_CHAR,
        S_NL,
        S_TICK,
        S_TNL
    } back_state_t;

    function automatic logic [6:0] map_char(input logic [5:0] v);
        logic [6:0] c;
        if (v == 6'd0)
            c = CHAR_BACKTICK;
        else
            c = CHAR_BASE + {1'b0, v};
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ule_intf.sv =====
// ============================================================================
// ule_intf: stream channels of the uuencode line encoder
// Raw byte channel in, text character channel out, both valid/ready.
// ============================================================================
`default_nettype none

interface ule_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_data;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_data, output ready);
endinterface

interface ule_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ule_ram.sv =====
// ============================================================================
// ule_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module ule_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ule_front.sv =====
// ============================================================================
// ule_front: byte intake and line bookkeeping
// Stores bytes into the current bank, counts the fill and issues commands.
// ============================================================================
`default_nettype none

module ule_front import ule_pkg::*; #(
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
    parameter int unsigned IDX_W      = $clog2(LINE_BYTES)
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ule_byte_if.sink        byte_ch,
    input  wire fifo_stat_t stat,
    output logic            push,
    output cmd_t            cmd,
    output logic            we,
    output logic [IDX_W:0]  waddr,
    output logic [7:0]      wdata
);

    logic [LEN_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic [LEN_W-1:0] fill_inc;
    logic             line_full;
    logic             has_line;

    assign byte_ch.ready = !stat.full;
    assign accept        = byte_ch.valid && byte_ch.ready;

    assign we    = accept && byte_ch.byte_valid;
    assign waddr = {bank_reg, fill_reg[IDX_W-1:0]};
    assign wdata = byte_ch.data_byte;

    always_comb
    begin
        fill_inc  = byte_ch.byte_valid ? fill_reg + LEN_W'(1) : fill_reg;
        line_full = byte_ch.byte_valid && (fill_inc == LEN_W'(LINE_BYTES));
        has_line  = line_full || (byte_ch.end_of_data && (fill_inc != '0));

        cmd.has_line = has_line;
        cmd.len      = fill_inc;
        cmd.bank     = bank_reg;
        cmd.has_term = byte_ch.end_of_data;

        push      = accept && (has_line || byte_ch.end_of_data);
        fill_next = fill_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            // a line emitted hands its bank to the back; switch to the other one
            fill_next = has_line ? '0 : fill_inc;
            bank_next = bank_reg ^ has_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            bank_reg <= bank_next;
        end
    end

    a_fill_below_line: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < LEN_W'(LINE_BYTES))
        else $error("fill count reached a full line without emitting it");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// ===== rtl/core/ule_cmd_fifo.sv =====
// ============================================================================
// ule_cmd_fifo: two-entry command queue between front and back
// The head stays in place until the back has finished the command.
// ============================================================================
`default_nettype none

module ule_cmd_fifo import ule_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output fifo_stat_t stat
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ule_back.sv =====
// ============================================================================
// ule_back: text generator
// Walks one command: length char, byte groups as 6-bit chars and newline for a line, then any terminator.
// ============================================================================
`default_nettype none

module ule_back import ule_pkg::*; #(
    parameter int unsigned IDX_W = $clog2(LINE_BYTES_DEF)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             head,
    input  wire fifo_stat_t       stat,
    output logic                  pop,
    output logic                  rd_en,
    output logic [IDX_W:0]        rd_addr,
    input  wire logic [7:0]       rd_data,
    ule_char_if.source            char_ch
);

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [1:0]       fk_reg, fk_next;
    logic [1:0]       ci_reg, ci_next;
    logic [23:0]      grp_reg, grp_next;
    logic             pend_reg;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       out_char_reg;
    logic             out_last_reg;

    logic             can_emit;
    logic             emit;
    logic [6:0]       emit_char;
    logic             emit_last;
    logic [LEN_W:0]   rd_pos;
    logic [LEN_W:0]   pos_plus3;
    logic             group_end;
    logic [5:0]       sixbit;

    assign can_emit  = !out_valid_reg || char_ch.ready;
    assign rd_pos    = {1'b0, pos_reg} + {{(LEN_W-1){1'b0}}, fk_reg};
    assign pos_plus3 = {1'b0, pos_reg} + (LEN_W+1)'(3);
    assign group_end = (pos_plus3 >= {1'b0, head.len});
    assign rd_addr   = {head.bank, rd_pos[IDX_W-1:0]};

    always_comb
    begin
        case (ci_reg)
            2'd0:    sixbit = grp_reg[23:18];
            2'd1:    sixbit = grp_reg[17:12];
            2'd2:    sixbit = grp_reg[11:6];
            default: sixbit = grp_reg[5:0];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!stat.empty)
                    state_next = head.has_line ? S_LEN : S_TICK;
            end
            S_LEN:
            begin
                if (can_emit)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (fk_reg == 2'd3)
                    state_next = S_CHAR;
            end
            S_CHAR:
            begin
                if (can_emit && (ci_reg == 2'd3))
                    state_next = group_end ? S_NL : S_FETCH;
            end
            S_NL:
            begin
                if (can_emit)
                    state_next = head.has_term ? S_TICK : S_IDLE;
            end
            S_TICK:
            begin
                if (can_emit)
                    state_next = S_TNL;
            end
            S_TNL:
            begin
                if (can_emit)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        emit      = 1'b0;
        emit_char = CHAR_NEWLINE;
        emit_last = 1'b0;
        pop       = 1'b0;
        rd_en     = 1'b0;
        case (state_reg)
            S_LEN:
            begin
                emit      = can_emit;
                emit_char = map_char(head.len);
            end
            S_FETCH:
            begin
                // bytes past the line end read as zero padding
                rd_en = (fk_reg != 2'd3) && (rd_pos < {1'b0, head.len});
            end
            S_CHAR:
            begin
                emit      = can_emit;
                emit_char = map_char(sixbit);
            end
            S_NL:
            begin
                emit      = can_emit;
                emit_char = CHAR_NEWLINE;
                emit_last = !head.has_term;
                pop       = can_emit && !head.has_term;
            end
            S_TICK:
            begin
                emit      = can_emit;
                emit_char = CHAR_BACKTICK;
            end
            S_TNL:
            begin
                emit      = can_emit;
                emit_char = CHAR_NEWLINE;
                emit_last = 1'b1;
                pop       = can_emit;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // group datapath
    always_comb
    begin
        pos_next = pos_reg;
        fk_next  = fk_reg;
        ci_next  = ci_reg;
        grp_next = grp_reg;
        case (state_reg)
            S_LEN:
            begin
                pos_next = '0;
                fk_next  = 2'd0;
            end
            S_FETCH:
            begin
                fk_next = fk_reg + 2'd1;
                ci_next = 2'd0;
                // read data arrives in the cycle after its address
                if (fk_reg != 2'd0)
                    grp_next = {grp_reg[15:0], pend_reg ? rd_data : 8'h00};
            end
            S_CHAR:
            begin
                if (can_emit)
                begin
                    ci_next = ci_reg + 2'd1;
                    if (ci_reg == 2'd3)
                    begin
                        pos_next = pos_plus3[LEN_W-1:0];
                        fk_next  = 2'd0;
                    end
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
        out_valid_next = emit || (out_valid_reg && !char_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            fk_reg        <= 2'd0;
            ci_reg        <= 2'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fk_reg        <= fk_next;
            ci_reg        <= ci_next;
            pend_reg      <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        if (emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign char_ch.valid       = out_valid_reg;
    assign char_ch.out_char    = out_char_reg;
    assign char_ch.last_of_run = out_last_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("command popped from an empty queue");

    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |-> pop)
        else $error("final character sent without retiring its command");

    a_fetch_has_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (!stat.empty && head.has_line))
        else $error("byte fetch without a pending line");

endmodule

`default_nettype wire

// ===== rtl/core/uuencode_line_encoder.sv =====
// ============================================================================
// uuencode_line_encoder: streaming uuencode of raw bytes into text lines
// Top level: front intake, command queue, line RAM and text generator.
// ============================================================================
// Bytes enter on byte_ch one beat at a time and are stored in one of two
// line banks; a full line, or end_of_data, queues a command and the back end
// turns it into characters on char_ch, one beat per character, with
// last_of_run marking the final character of each input beat. Input beats
// are accepted while the two-entry command queue has room, so one line can
// be filled while the previous one is sent. The back end picks up each
// command from its idle state, sends the length character, then for each
// group of three bytes fetches the bytes through the single RAM read port
// and sends four characters, then the newline; a terminator adds a
// backtick and a newline.
`default_nettype none

module uuencode_line_encoder import ule_pkg::*; #(
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ule_byte_if.sink   byte_ch,
    ule_char_if.source char_ch
);

    localparam int unsigned IDX_W     = $clog2(LINE_BYTES);
    localparam int unsigned RAM_DEPTH = 2 * (2 ** IDX_W);

    logic            push;
    cmd_t            push_cmd;
    logic            pop;
    cmd_t            head;
    fifo_stat_t      stat;
    logic            we;
    logic [IDX_W:0]  waddr;
    logic [7:0]      wdata;
    logic            rd_en;
    logic [IDX_W:0]  rd_addr;
    logic [7:0]      rd_data;

    ule_front #(
        .LINE_BYTES (LINE_BYTES),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .stat    (stat),
        .push    (push),
        .cmd     (push_cmd),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata)
    );

    ule_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    ule_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ule_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .char_ch (char_ch)
    );

endmodule

`default_nettype wire

// ===== tb/uuencode_line_encoder_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uuencode_line_encoder_tb: self-checking bench for the uuencode line encoder
// Drives raw byte beats through the byte channel, predicts the text of every
// line and terminator, and checks each character beat and its last_of_run
// flag in order, under several sender/receiver idling mixes and a long stall.
// ============================================================================

module uuencode_line_encoder_tb;
    import ule_pkg::*;

    localparam int unsigned LINE_LEN = LINE_BYTES_DEF;

    class uu_line_scoreboard;
        bit [7:0]    line_bytes[64];
        int unsigned line_fill;
        bit [7:0]    pending_text[$];   // {last_of_run, out_char}
        int unsigned errors;

        task report(input string msg);
            if (errors < 100)
                $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function bit [6:0] sixbit_char(input bit [5:0] v);
            if (v == 6'd0)
                return CHAR_BACKTICK;
            return CHAR_BASE + {1'b0, v};
        endfunction

        function void push_char(input bit [6:0] c);
            pending_text.push_back({1'b0, c});
        endfunction

        function void predict_line_text();
            bit [7:0]    b0;
            bit [7:0]    b1;
            bit [7:0]    b2;
            int unsigned i;
            push_char(sixbit_char(6'(line_fill)));
            for (i = 0; i < line_fill; i += 3)
            begin
                b0 = line_bytes[i];
                b1 = (i + 1 < line_fill) ? line_bytes[i + 1] : 8'h00;
                b2 = (i + 2 < line_fill) ? line_bytes[i + 2] : 8'h00;
                push_char(sixbit_char(b0[7:2]));
                push_char(sixbit_char({b0[1:0], b1[7:4]}));
                push_char(sixbit_char({b1[3:0], b2[7:6]}));
                push_char(sixbit_char(b2[5:0]));
            end
            push_char(CHAR_NEWLINE);
            line_fill = 0;
        endfunction

        function void note_beat(input bit [7:0] d, input bit bv, input bit eod);
            int unsigned depth0;
            depth0 = pending_text.size();
            if (bv)
            begin
                line_bytes[line_fill] = d;
                line_fill++;
                if (line_fill >= LINE_LEN)
                    predict_line_text();
            end
            if (eod)
            begin
                if (line_fill > 0)
                    predict_line_text();
                push_char(CHAR_BACKTICK);
                push_char(CHAR_NEWLINE);
            end
            // mark the final character caused by this beat
            if (pending_text.size() > depth0)
                pending_text[pending_text.size() - 1][7] = 1'b1;
        endfunction

        task check_char(input logic [6:0] c, input logic last);
            bit [7:0] want;
            if (pending_text.size() == 0)
            begin
                report($sformatf("char beat 0x%02h last %b with nothing expected", c, last));
                return;
            end
            want = pending_text.pop_front();
            if (c !== want[6:0])
                report($sformatf("out_char 0x%02h, expected 0x%02h", c, want[6:0]));
            if (last !== want[7])
                report($sformatf("last_of_run %b, expected %b (char 0x%02h)",
                                 last, want[7], want[6:0]));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ule_byte_if byte_ch ();
    ule_char_if char_ch ();

    uu_line_scoreboard line_board;

    int unsigned items_sent;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned hold_left;

    uuencode_line_encoder #(.LINE_BYTES(LINE_LEN)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .char_ch (char_ch)
    );

    always #5 clk = ~clk;

    // Note input beats before checking output so a same-edge beat is never missed
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (byte_ch.valid && byte_ch.ready)
                line_board.note_beat(byte_ch.data_byte, byte_ch.byte_valid,
                                     byte_ch.end_of_data);
            if (char_ch.valid && char_ch.ready)
                line_board.check_char(char_ch.out_char, char_ch.last_of_run);
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial
    begin
        char_ch.ready <= 1'b0;
        holds_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_ch.ready <= 1'b0;
            end
            else
                char_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic bv, input logic eod);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= d;
        byte_ch.byte_valid  <= bv;
        byte_ch.end_of_data <= eod;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        if (bv || eod)
            items_sent++;
    endtask

    // Send whole streams of random length with random content, ended in mixed ways
    task automatic run_streams(input int unsigned target);
        int unsigned goal;
        int unsigned len;
        int unsigned k;
        int unsigned pick;
        int unsigned end_mode;
        logic [7:0]  d;
        goal = items_sent + target;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                len = $urandom_range(12, 1);
            else if (pick < 70)
                len = $urandom_range(LINE_LEN - 1, 13);
            else if (pick < 85)
                len = LINE_LEN * $urandom_range(2, 1);
            else if (pick < 93)
                len = $urandom_range(2 * LINE_LEN + 10, LINE_LEN + 1);
            else
                len = 0;
            // trim the last stream so the phase stays near its item count
            if (len > goal - items_sent)
                len = goal - items_sent;
            end_mode = $urandom_range(3);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(9) == 0)
                    send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                pick = $urandom_range(15);
                d = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
                send_beat(d, 1'b1, (k == len - 1) && (end_mode < 2));
            end
            // separate flush beat; an empty stream always ends this way
            if (len == 0 || end_mode == 2)
                send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        line_board = new();
        items_sent = 0;
        hold_requests = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= 8'h00;
        byte_ch.byte_valid  <= 1'b0;
        byte_ch.end_of_data <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // terminator on an empty line, then a beat with no byte and no end
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'hA5, 1'b0, 1'b0);
        // full group, end carried on the last byte
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b1);
        // two-byte short group, flushed by a separate end beat
        send_beat(8'h7F, 1'b1, 1'b0);
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // one-byte line right after an end
        send_beat(8'hFE, 1'b1, 1'b1);
        // four bytes: one full group and a one-byte tail
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'hAA, 1'b1, 1'b0);
        send_beat(8'h3C, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);

        // no idling; long receiver hold-off so the input backs up
        hold_requests <= hold_requests + 1;
        run_streams(100);

        sender_idle_pct <= 71;
        run_streams(100);

        sender_idle_pct    <= 0;
        receiver_stall_pct <= 71;
        run_streams(100);

        sender_idle_pct    <= 29;
        receiver_stall_pct <= 29;
        run_streams(110);

        byte_ch.valid      <= 1'b0;
        receiver_stall_pct <= 0;
        while (line_board.pending_text.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (line_board.errors == 0)
            $display("uuencode_line_encoder: match");
        else
            $display("uuencode_line_encoder: mismatch");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("TIMEOUT @%0t: %0d characters still expected", $time,
                 line_board.pending_text.size());
        $display("uuencode_line_encoder: mismatch");
        $finish;
    end

endmodule
